FILE: src/gbn_pkg.sv
// Package: shared widths, codes and beat types of the go-back-N sender window.
`default_nettype none
package gbn_pkg;

	// Field widths of the event and result beats.
	localparam int REQ_W = 2;
	localparam int ACK_W = 25;
	localparam int LEN_W = 24;
	localparam int SEG_IDX_W = 18;

	// Configuration port.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_MESSAGES = 1'd1;
	localparam logic [LEN_W-1:0] FILE_LENGTH_RESET = '0;
	localparam logic [SEG_IDX_W-1:0] TOTAL_MESSAGES_RESET = 18'd1;

	// Defaults of the top-level parameters.
	localparam int WINDOW_DEFAULT = 4;
	localparam int SEGMENT_BYTES_DEFAULT = 124;

	// Fixed protocol limits.
	localparam int MAX_RESULTS = 4;
	localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int DUP_LIMIT = 3;
	localparam int DUP_W = 2;
	localparam int QUEUE_DEPTH = 2;

	// Request codes on the event channel.
	localparam logic [REQ_W-1:0] REQ_START = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ACK = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

	// Result kinds.
	localparam logic RESULT_SEND = 1'b0;
	localparam logic RESULT_DONE = 1'b1;

	// Classified command passed from the front end to the engine.
	typedef enum logic [1:0] {
		OP_START,
		OP_ACK,
		OP_TIMEOUT
	} op_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [ACK_W-1:0] ack_value;
	} evt_t;

	typedef struct packed {
		logic                 result_kind;
		logic [SEG_IDX_W-1:0] segment_index;
		logic [LEN_W-1:0]     segment_end_byte;
		logic                 last_of_run;
	} res_t;

	typedef struct packed {
		op_t              op;
		logic [ACK_W-1:0] ack_value;
	} cmd_t;

endpackage
`default_nettype wire

FILE: src/go_back_n_sender_window.sv
// Top level: go-back-N sender window with configuration registers and front/back split.
// Each event beat is classified by a front end; beats with a used code are parked in a
// two-entry command queue, so the event port takes beats while the engine works or the
// result port stalls, as long as there is room. The engine handles one event at a time:
// it takes the event from the queue, evaluates it, issues its results (at most four),
// holding while the result port stalls, and, unless the run ends on a completion,
// closes with a check that finds nothing more to send; an ack or timeout after
// completion is only taken and evaluated. A rewind (third duplicate ack or a timeout)
// first runs the reciprocal division of the ack by the segment size (multiply,
// remainder, correction) and the end-byte multiply. No clearing pass follows reset.
`default_nettype none
module go_back_n_sender_window #(
	parameter int WINDOW = gbn_pkg::WINDOW_DEFAULT,
	parameter int SEGMENT_BYTES = gbn_pkg::SEGMENT_BYTES_DEFAULT
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic cfg_write_en,
	input  wire                logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire                logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                logic evt_valid,
	output logic               evt_ready,
	input  wire gbn_pkg::evt_t evt_data,
	output logic               res_valid,
	input  wire                logic res_ready,
	output gbn_pkg::res_t      res_data
);

	logic [gbn_pkg::LEN_W-1:0]     file_length_q;
	logic [gbn_pkg::SEG_IDX_W-1:0] total_messages_q;
	logic                          q_push;
	gbn_pkg::cmd_t                 q_push_data;
	logic                          q_full;
	logic                          q_pop;
	logic                          q_valid;
	gbn_pkg::cmd_t                 q_pop_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= gbn_pkg::FILE_LENGTH_RESET;
			total_messages_q <= gbn_pkg::TOTAL_MESSAGES_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				gbn_pkg::REG_FILE_LENGTH: file_length_q <= cfg_data[gbn_pkg::LEN_W-1:0];
				gbn_pkg::REG_TOTAL_MESSAGES: total_messages_q <= cfg_data[gbn_pkg::SEG_IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// Front end.
	gbn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt_valid  (evt_valid),
		.evt_ready  (evt_ready),
		.evt_data   (evt_data),
		.push       (q_push),
		.push_data  (q_push_data),
		.queue_full (q_full)
	);

	// Command queue.
	gbn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_pop_data)
	);

	// Engine.
	gbn_engine #(
		.WINDOW        (WINDOW),
		.SEGMENT_BYTES (SEGMENT_BYTES)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.file_length    (file_length_q),
		.total_messages (total_messages_q),
		.cmd_valid      (q_valid),
		.cmd_data       (q_pop_data),
		.cmd_pop        (q_pop),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res_data       (res_data)
	);

`ifndef SYNTHESIS
	// A completion always closes its run.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_data.result_kind == gbn_pkg::RESULT_DONE)) |-> res_data.last_of_run)
		else $error("completion beat not marked as last of run");

	// A completion carries segment index zero and the file length.
	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_data.result_kind == gbn_pkg::RESULT_DONE)) |->
		((res_data.segment_index == '0) && (res_data.segment_end_byte == file_length_q)))
		else $error("completion beat carries wrong fields");

	// A send command never points past the end of the file.
	a_end_in_file: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_data.result_kind == gbn_pkg::RESULT_SEND)) |->
		(res_data.segment_end_byte <= file_length_q))
		else $error("send command end byte beyond file length");
`endif

endmodule
`default_nettype wire

FILE: src/gbn_front.sv
// Front end: takes event beats, drops unused codes and holds one classified command.
`default_nettype none
module gbn_front (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic evt_valid,
	output logic               evt_ready,
	input  wire gbn_pkg::evt_t evt_data,
	output logic               push,
	output gbn_pkg::cmd_t      push_data,
	input  wire                logic queue_full
);

	logic          hold_valid_q;
	gbn_pkg::cmd_t hold_cmd_q;
	gbn_pkg::cmd_t dec_cmd;
	logic          dec_keep;
	logic          accept;

	// Decode the request code into an engine command.
	always_comb begin
		dec_cmd.ack_value = evt_data.ack_value;
		dec_cmd.op = gbn_pkg::OP_START;
		dec_keep = 1'b1;
		case (evt_data.req_type)
			gbn_pkg::REQ_START: dec_cmd.op = gbn_pkg::OP_START;
			gbn_pkg::REQ_ACK: dec_cmd.op = gbn_pkg::OP_ACK;
			gbn_pkg::REQ_TIMEOUT: dec_cmd.op = gbn_pkg::OP_TIMEOUT;
			default: dec_keep = 1'b0;
		endcase
	end

	// The holding register frees itself in the cycle its command enters the queue.
	assign push = hold_valid_q && !queue_full;
	assign push_data = hold_cmd_q;
	assign evt_ready = !hold_valid_q || push;
	assign accept = evt_valid && evt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (accept) begin
			hold_valid_q <= dec_keep;
		end else if (push) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && dec_keep) begin
			hold_cmd_q <= dec_cmd;
		end
	end

endmodule
`default_nettype wire

FILE: src/gbn_queue.sv
// Command queue: a short first-in first-out buffer between front end and engine.
`default_nettype none
module gbn_queue (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic push,
	input  wire gbn_pkg::cmd_t push_data,
	output logic               full,
	input  wire                logic pop,
	output logic               valid,
	output gbn_pkg::cmd_t      pop_data
);

	localparam int PTR_W = $clog2(gbn_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(gbn_pkg::QUEUE_DEPTH + 1);

	gbn_pkg::cmd_t          entry_q [gbn_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;

	assign full = (count_q == CNT_W'(gbn_pkg::QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(gbn_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(gbn_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

FILE: src/gbn_engine.sv
// Engine: window state, rewind by reciprocal division and the result sequencer.
`default_nettype none
module gbn_engine #(
	parameter int WINDOW = gbn_pkg::WINDOW_DEFAULT,
	parameter int SEGMENT_BYTES = gbn_pkg::SEGMENT_BYTES_DEFAULT
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic [gbn_pkg::LEN_W-1:0] file_length,
	input  wire                logic [gbn_pkg::SEG_IDX_W-1:0] total_messages,
	input  wire                logic cmd_valid,
	input  wire gbn_pkg::cmd_t cmd_data,
	output logic               cmd_pop,
	output logic               res_valid,
	input  wire                logic res_ready,
	output gbn_pkg::res_t      res_data
);

	localparam int ACK_W = gbn_pkg::ACK_W;
	localparam int LEN_W = gbn_pkg::LEN_W;
	localparam int IDX_W = gbn_pkg::SEG_IDX_W;
	localparam int CNT_W = gbn_pkg::RES_CNT_W;
	localparam int DUP_W = gbn_pkg::DUP_W;
	localparam int WIN_W = $clog2(WINDOW + 1);
	localparam int SEG_W = $clog2(SEGMENT_BYTES + 1);
	localparam int END_RAW_W = IDX_W + SEG_W;
	localparam int END_W = (END_RAW_W > LEN_W) ? END_RAW_W : LEN_W;
	// Reciprocal of the segment size scaled by 2^ACK_W; the estimate is low by at most one.
	localparam int unsigned RECIP = (1 << ACK_W) / SEGMENT_BYTES;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W = ACK_W + RECIP_W;
	localparam int QD_W = RECIP_W + SEG_W;
	localparam int CMPQ_W = (RECIP_W > IDX_W) ? RECIP_W : IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV_MUL,
		ST_DIV_REM,
		ST_DIV_FIX,
		ST_END_MUL,
		ST_SEND
	} state_t;

	state_t               state_q;
	gbn_pkg::cmd_t        cmd_q;
	logic [IDX_W-1:0]     next_seg_q;
	logic [WIN_W-1:0]     window_q;
	logic [ACK_W-1:0]     highest_q;
	logic [ACK_W-1:0]     latest_q;
	logic [DUP_W-1:0]     dup_q;
	logic                 finished_q;
	logic [CNT_W-1:0]     n_q;
	logic [END_W-1:0]     end_acc_q;
	logic [PROD_W-1:0]    prod_q;
	logic [RECIP_W-1:0]   quot_q;
	logic [SEG_W:0]       rem_q;
	logic                 res_valid_q;
	gbn_pkg::res_t        res_q;

	logic                 slot_free;
	logic                 ack_covered;
	logic                 can_send;
	logic                 can_done;
	logic                 more_after;
	logic [CNT_W-1:0]     n_inc;
	logic [IDX_W-1:0]     seg_inc;
	logic [WIN_W-1:0]     win_inc;
	logic [LEN_W-1:0]     end_clip;
	logic [DUP_W-1:0]     dup_inc;
	logic [RECIP_W-1:0]   quot_est;
	logic [QD_W-1:0]      quot_times_seg;
	logic [ACK_W-1:0]     rem_full;
	logic [RECIP_W-1:0]   quot_fix;
	logic [CMPQ_W-1:0]    seg_sat;
	logic [END_W-1:0]     next_plus_one;

	// Send and completion conditions, looking one result ahead to mark the last one.
	always_comb begin
		slot_free = !res_valid_q || res_ready;
		ack_covered = (latest_q >= {1'b0, file_length});
		n_inc = n_q + 1'b1;
		seg_inc = next_seg_q + 1'b1;
		win_inc = window_q + 1'b1;
		can_send = (n_q < CNT_W'(gbn_pkg::MAX_RESULTS)) && (next_seg_q < total_messages)
			&& (window_q < WIN_W'(WINDOW));
		can_done = (n_q < CNT_W'(gbn_pkg::MAX_RESULTS)) && (next_seg_q >= total_messages)
			&& ack_covered;
		more_after = (n_inc < CNT_W'(gbn_pkg::MAX_RESULTS))
			&& (((seg_inc < total_messages) && (win_inc < WIN_W'(WINDOW)))
			|| ((seg_inc >= total_messages) && ack_covered));
		end_clip = (end_acc_q > END_W'(file_length)) ? file_length : end_acc_q[LEN_W-1:0];
		dup_inc = dup_q + 1'b1;
	end

	// Division datapath: estimate, remainder, then a single correction and saturation.
	always_comb begin
		quot_est = prod_q[ACK_W +: RECIP_W];
		quot_times_seg = QD_W'(quot_est) * QD_W'(SEGMENT_BYTES);
		rem_full = latest_q - ACK_W'(quot_times_seg);
		quot_fix = quot_q + RECIP_W'(rem_q >= (SEG_W + 1)'(SEGMENT_BYTES));
		seg_sat = (CMPQ_W'(quot_fix) > CMPQ_W'(total_messages)) ?
			CMPQ_W'(total_messages) : CMPQ_W'(quot_fix);
		next_plus_one = END_W'(next_seg_q) + END_W'(1);
	end

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign res_valid = res_valid_q;
	assign res_data = res_q;

	// Sequencer, window state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q <= '0;
			next_seg_q <= '0;
			window_q <= '0;
			highest_q <= '0;
			latest_q <= '0;
			dup_q <= '0;
			finished_q <= 1'b0;
			n_q <= '0;
			end_acc_q <= END_W'(SEGMENT_BYTES);
			prod_q <= '0;
			quot_q <= '0;
			rem_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd_data;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					n_q <= '0;
					case (cmd_q.op)
						gbn_pkg::OP_START: begin
							next_seg_q <= '0;
							window_q <= '0;
							highest_q <= '0;
							latest_q <= '0;
							dup_q <= '0;
							finished_q <= 1'b0;
							end_acc_q <= END_W'(SEGMENT_BYTES);
							state_q <= ST_SEND;
						end
						gbn_pkg::OP_ACK: begin
							if (finished_q) begin
								state_q <= ST_IDLE;
							end else begin
								latest_q <= cmd_q.ack_value;
								state_q <= ST_SEND;
								if (cmd_q.ack_value > highest_q) begin
									highest_q <= cmd_q.ack_value;
									if (window_q != '0) begin
										window_q <= window_q - 1'b1;
									end
									dup_q <= '0;
								end else if (cmd_q.ack_value == highest_q) begin
									dup_q <= dup_inc;
									if (dup_inc == DUP_W'(gbn_pkg::DUP_LIMIT)) begin
										state_q <= ST_DIV_MUL;
									end
								end
							end
						end
						gbn_pkg::OP_TIMEOUT: begin
							state_q <= finished_q ? ST_IDLE : ST_DIV_MUL;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_DIV_MUL: begin
					prod_q <= PROD_W'(latest_q) * PROD_W'(RECIP);
					state_q <= ST_DIV_REM;
				end
				ST_DIV_REM: begin
					quot_q <= quot_est;
					rem_q <= rem_full[SEG_W:0];
					state_q <= ST_DIV_FIX;
				end
				ST_DIV_FIX: begin
					next_seg_q <= seg_sat[IDX_W-1:0];
					window_q <= '0;
					dup_q <= '0;
					state_q <= ST_END_MUL;
				end
				ST_END_MUL: begin
					end_acc_q <= END_W'(next_plus_one * END_W'(SEGMENT_BYTES));
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (can_send) begin
						if (slot_free) begin
							res_valid_q <= 1'b1;
							res_q.result_kind <= gbn_pkg::RESULT_SEND;
							res_q.segment_index <= next_seg_q;
							res_q.segment_end_byte <= end_clip;
							res_q.last_of_run <= !more_after;
							n_q <= n_inc;
							next_seg_q <= seg_inc;
							window_q <= win_inc;
							end_acc_q <= end_acc_q + END_W'(SEGMENT_BYTES);
						end
					end else if (can_done) begin
						if (slot_free) begin
							res_valid_q <= 1'b1;
							res_q.result_kind <= gbn_pkg::RESULT_DONE;
							res_q.segment_index <= '0;
							res_q.segment_end_byte <= file_length;
							res_q.last_of_run <= 1'b1;
							finished_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
